// ===== rtl/core/lmbc_pkg.sv =====
// lmbc_pkg: shared constants, register indexes and control codes of the
// logistic map byte cipher
// no dependencies
`default_nettype none

package lmbc_pkg;

  localparam int unsigned VALUE_BITS_DEF   = 32;
  localparam int unsigned MU_FRAC_BITS_DEF = 30;

  // mu reset given in Q2.30, rescaled to the fraction width at elaboration
  localparam logic [63:0] MU_RESET_Q30   = 64'd4282263716;
  localparam int unsigned MU_RESET_FRAC  = 30;
  localparam logic [63:0] PREC_RESET     = 64'd1000000;

  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_MU_Q         = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRECISION    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SEED         = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_JUMP_MODE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DECRYPT_MODE = 3'd4;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_SEED,
    OP_LOAD,
    OP_MUL,
    OP_MID,
    OP_DIVLD,
    OP_DIV,
    OP_WB
  } lmbc_op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_MUL1,
    S_MID,
    S_MUL2,
    S_DIVLD,
    S_DIV,
    S_WB
  } lmbc_state_e;

  typedef struct packed {
    lmbc_op_e op;
    logic     busy;
  } lmbc_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/core/lmbc_dp.sv =====
// lmbc_dp: state register and shared adder datapath for one map step
// (shift-add multiply, restoring divide); uses lmbc_pkg
`default_nettype none

module lmbc_dp #(
  parameter int unsigned VB = lmbc_pkg::VALUE_BITS_DEF,
  parameter int unsigned FB = lmbc_pkg::MU_FRAC_BITS_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire lmbc_pkg::lmbc_ctl_t ctl_i,
  input  wire logic [VB-1:0]       p_i,
  input  wire logic [FB+2:0]       mu_i,
  input  wire logic [VB-1:0]       seed_i,
  output logic      [VB-1:0]       k_o
);
  import lmbc_pkg::*;

  localparam int unsigned MU_W = FB + 3;
  localparam int unsigned PW   = 2 * VB + MU_W;
  localparam int unsigned ML   = (VB > MU_W) ? VB : MU_W;
  localparam logic [MU_W-1:0] MuCap = MU_W'(4) << FB;

  logic [VB-1:0]   k_q, k_d;
  logic [PW-1:0]   acc_q, acc_d;
  logic [2*VB-1:0] mcand_q, mcand_d;
  logic [ML-1:0]   mplier_q, mplier_d;
  logic [VB-1:0]   rem_q, rem_d;
  logic [VB-1:0]   quo_q, quo_d;

  logic [PW-1:0]   add_a, add_b, add_s;
  logic            add_ci;
  logic [VB-1:0]   kc;
  logic [MU_W-1:0] mu_eff;
  logic [VB:0]     div_t;
  logic            div_ge;

  assign kc     = (k_q > p_i) ? p_i : k_q;
  assign mu_eff = (mu_i > MuCap) ? MuCap : mu_i;
  assign div_t  = {rem_q, quo_q[VB-1]};
  assign div_ge = ~add_s[PW-1];

  // single shared adder
  always_comb begin
    add_a  = '0;
    add_b  = '0;
    add_ci = 1'b0;
    case (ctl_i.op)
      OP_LOAD: begin
        add_a  = PW'(p_i);
        add_b  = ~PW'(kc);
        add_ci = 1'b1;
      end
      OP_MUL: begin
        add_a = acc_q << 1;
        add_b = mplier_q[ML-1] ? PW'(mcand_q) : '0;
      end
      OP_DIV: begin
        add_a  = PW'(div_t);
        add_b  = ~PW'(p_i);
        add_ci = 1'b1;
      end
      default: begin
      end
    endcase
    add_s = add_a + add_b + PW'(add_ci);
  end

  always_comb begin
    k_d      = k_q;
    acc_d    = acc_q;
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    rem_d    = rem_q;
    quo_d    = quo_q;
    case (ctl_i.op)
      OP_SEED: begin
        k_d = seed_i;
      end
      OP_LOAD: begin
        mcand_d  = (2*VB)'(kc);
        mplier_d = ML'(add_s[VB-1:0]) << (ML - VB);
        acc_d    = '0;
      end
      OP_MUL: begin
        acc_d    = add_s;
        mplier_d = mplier_q << 1;
      end
      OP_MID: begin
        mcand_d  = acc_q[2*VB-1:0];
        mplier_d = ML'(mu_eff) << (ML - MU_W);
        acc_d    = '0;
      end
      OP_DIVLD: begin
        rem_d = acc_q[FB+VB +: VB];
        quo_d = acc_q[FB +: VB];
      end
      OP_DIV: begin
        rem_d = div_ge ? add_s[VB-1:0] : div_t[VB-1:0];
        quo_d = {quo_q[VB-2:0], div_ge};
      end
      OP_WB: begin
        k_d = (quo_q > p_i) ? p_i : quo_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q <= '0;
    end else begin
      k_q <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q    <= acc_d;
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
    rem_q    <= rem_d;
    quo_q    <= quo_d;
  end

  assign k_o = k_q;

endmodule

`default_nettype wire

// ===== rtl/core/lmbc_ctrl.sv =====
// lmbc_ctrl: sequencer for the map steps of one word, with bit and step counters
// uses lmbc_pkg
`default_nettype none

module lmbc_ctrl #(
  parameter int unsigned VB = lmbc_pkg::VALUE_BITS_DEF,
  parameter int unsigned FB = lmbc_pkg::MU_FRAC_BITS_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                accept_i,
  input  wire logic                start_i,
  input  wire logic [7:0]          steps_i,
  output lmbc_pkg::lmbc_ctl_t      ctl_o
);
  import lmbc_pkg::*;

  localparam int unsigned MU_W = FB + 3;
  localparam int unsigned ML   = (VB > MU_W) ? VB : MU_W;
  localparam int unsigned CW   = $clog2(ML);

  lmbc_state_e state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [7:0]    steps_q, steps_d;
  lmbc_op_e      op;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept_i && (steps_i != 8'd0)) begin
          state_d = S_LOAD;
        end
      end
      S_LOAD: state_d = S_MUL1;
      S_MUL1: begin
        if (cnt_q == '0) begin
          state_d = S_MID;
        end
      end
      S_MID: state_d = S_MUL2;
      S_MUL2: begin
        if (cnt_q == '0) begin
          state_d = S_DIVLD;
        end
      end
      S_DIVLD: state_d = S_DIV;
      S_DIV: begin
        if (cnt_q == '0) begin
          state_d = S_WB;
        end
      end
      S_WB: begin
        state_d = (steps_q == 8'd1) ? S_IDLE : S_LOAD;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    op      = OP_HOLD;
    cnt_d   = cnt_q;
    steps_d = steps_q;
    case (state_q)
      S_IDLE: begin
        if (accept_i) begin
          steps_d = steps_i;
          op      = start_i ? OP_SEED : OP_HOLD;
        end
      end
      S_LOAD: begin
        op    = OP_LOAD;
        cnt_d = CW'(VB - 1);
      end
      S_MUL1: begin
        op    = OP_MUL;
        cnt_d = cnt_q - 1'b1;
      end
      S_MID: begin
        op    = OP_MID;
        cnt_d = CW'(MU_W - 1);
      end
      S_MUL2: begin
        op    = OP_MUL;
        cnt_d = cnt_q - 1'b1;
      end
      S_DIVLD: begin
        op    = OP_DIVLD;
        cnt_d = CW'(VB - 1);
      end
      S_DIV: begin
        op    = OP_DIV;
        cnt_d = cnt_q - 1'b1;
      end
      S_WB: begin
        op      = OP_WB;
        steps_d = steps_q - 8'd1;
      end
      default: op = OP_HOLD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      steps_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      steps_q <= steps_d;
    end
  end

  assign ctl_o.op   = op;
  assign ctl_o.busy = (state_q != S_IDLE);

endmodule

`default_nettype wire

// ===== rtl/core/logistic_map_byte_cipher_top.sv =====
// Logistic map byte cipher: each word is XORed with the low byte of the state k,
// then k advances by k' = floor(mu*k*(P-k)/(P*2^MU_FRAC_BITS)), once per word or,
// in jump mode, as many times as the ciphertext byte. The result word is known at
// acceptance and held in an output register. One map step runs on a single shared
// adder: a load, a shift-add multiply k*(P-k), a mid step, a shift-add multiply by
// mu, a divide load, a restoring divide by P and a write-back, in that order.
// A word therefore keeps the input stalled while its map steps run: one step in
// normal mode and up to 255 in jump mode; a jump count of zero leaves the input
// free at once. Depends on lmbc_pkg, lmbc_ctrl and lmbc_dp.
`default_nettype none

module logistic_map_byte_cipher_top #(
  parameter int unsigned VALUE_BITS   = lmbc_pkg::VALUE_BITS_DEF,
  parameter int unsigned MU_FRAC_BITS = lmbc_pkg::MU_FRAC_BITS_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [lmbc_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [((VALUE_BITS > MU_FRAC_BITS + 3) ?
                      VALUE_BITS : MU_FRAC_BITS + 3)-1:0] cfg_data_i,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic [7:0]                         data_byte_i,
  input  wire logic                               start_of_message_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic [7:0]                              result_byte_o
);
  import lmbc_pkg::*;

  localparam int unsigned VB   = VALUE_BITS;
  localparam int unsigned FB   = MU_FRAC_BITS;
  localparam int unsigned MU_W = FB + 3;
  localparam logic [MU_W-1:0] MuReset = (FB >= MU_RESET_FRAC) ?
      (MU_W'(MU_RESET_Q30) << (FB - MU_RESET_FRAC)) :
      MU_W'(MU_RESET_Q30 >> (MU_RESET_FRAC - FB));
  localparam logic [VB-1:0]   PrecReset = VB'(PREC_RESET);

  logic [MU_W-1:0] mu_q;
  logic [VB-1:0]   prec_q, seed_q;
  logic            jump_q, decrypt_q;
  logic            out_valid_q, out_valid_d;
  logic [7:0]      result_q, result_d;

  logic            in_acc;
  logic [VB-1:0]   p_eff, seed_sat, k;
  logic [7:0]      cur_byte, res, cipher, steps;
  lmbc_ctl_t       ctl;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mu_q      <= MuReset;
      prec_q    <= PrecReset;
      seed_q    <= '0;
      jump_q    <= 1'b0;
      decrypt_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MU_Q:         mu_q      <= cfg_data_i[MU_W-1:0];
        REG_PRECISION:    prec_q    <= cfg_data_i[VB-1:0];
        REG_SEED:         seed_q    <= cfg_data_i[VB-1:0];
        REG_JUMP_MODE:    jump_q    <= cfg_data_i[0];
        REG_DECRYPT_MODE: decrypt_q <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  assign p_eff    = (prec_q == '0) ? VB'(1) : prec_q;
  assign seed_sat = (seed_q > p_eff) ? p_eff : seed_q;
  assign cur_byte = start_of_message_i ? seed_sat[7:0] : k[7:0];
  assign res      = data_byte_i ^ cur_byte;
  assign cipher   = decrypt_q ? data_byte_i : res;
  assign steps    = jump_q ? cipher : 8'd1;

  assign in_stall_o = ctl.busy || (out_valid_q && out_stall_i);
  assign in_acc     = in_valid_i && !in_stall_o;

  // output word register
  always_comb begin
    out_valid_d = out_valid_q;
    result_d    = result_q;
    if (in_acc) begin
      out_valid_d = 1'b1;
      result_d    = res;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  assign out_valid_o   = out_valid_q;
  assign result_byte_o = result_q;

  lmbc_ctrl #(
    .VB (VB),
    .FB (FB)
  ) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_acc),
    .start_i  (start_of_message_i),
    .steps_i  (steps),
    .ctl_o    (ctl)
  );

  lmbc_dp #(
    .VB (VB),
    .FB (FB)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl),
    .p_i    (p_eff),
    .mu_i   (mu_q),
    .seed_i (seed_sat),
    .k_o    (k)
  );

endmodule

`default_nettype wire

// ===== rtl/core/lmbc_checker.sv =====
// lmbc_checker: port-level checks of the cipher's handshakes over time
// bound to logistic_map_byte_cipher_top
`default_nettype none

module lmbc_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_stall_o,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic [7:0] result_byte_o
);

  // no new word while a result word is held back
  a_no_accept_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> !(in_valid_i && !in_stall_o))
    else $error("input word taken while output word is stalled");

  // every accepted word gives a result word next cycle
  a_result_follows_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> out_valid_o)
    else $error("accepted word produced no result word");

  // result words only appear after an accepted word
  a_no_spurious_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o))
    else $error("result word without an accepted input word");

  // stalled result word holds
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(result_byte_o)))
    else $error("stalled result word changed or dropped");

endmodule

bind logistic_map_byte_cipher_top lmbc_checker u_lmbc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .result_byte_o (result_byte_o)
);

`default_nettype wire

// ===== sim/tb_logistic_map_byte_cipher_top.sv =====
// tb_logistic_map_byte_cipher_top: self-checking bench for the logistic map byte cipher,
// random phases of register settings with random idling and stalls on both sides
// depends on lmbc_pkg and logistic_map_byte_cipher_top
`timescale 1ns / 100ps

module tb_logistic_map_byte_cipher_top;
  import lmbc_pkg::*;

  localparam int unsigned VB          = VALUE_BITS_DEF;
  localparam int unsigned MF          = MU_FRAC_BITS_DEF;
  localparam int unsigned CFG_W       = (VB > MF + 3) ? VB : MF + 3;
  localparam int unsigned STEP_CYCLES = 2 * VB + MF + 7;
  localparam int unsigned TOTAL_WORDS = 1170;
  localparam int unsigned HOLD_CYCLES = 600;
  localparam int unsigned QUIET_LIMIT = 200000;
  localparam bit [32:0]   MU_CAP      = 33'd4 << MF;
  localparam bit [32:0]   MU_RESET    = 33'd4282263716;

  class byte_cipher_checker;
    bit [32:0]   mu_q;
    bit [31:0]   precision;
    bit [31:0]   seed;
    bit          jump_mode;
    bit          decrypt_mode;
    bit [31:0]   chaos;
    bit [7:0]    expected_bytes[$];
    int unsigned errors;
    int unsigned words_in;
    int unsigned words_out;
    int unsigned last_steps;

    function new();
      mu_q         = MU_RESET;
      precision    = 32'd1000000;
      seed         = 32'd0;
      jump_mode    = 1'b0;
      decrypt_mode = 1'b0;
      chaos        = 32'd0;
      errors       = 0;
      words_in     = 0;
      words_out    = 0;
      last_steps   = 1;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, bit [CFG_W-1:0] value);
      case (idx)
        REG_MU_Q:         mu_q = value[32:0];
        REG_PRECISION:    precision = value[31:0];
        REG_SEED:         seed = value[31:0];
        REG_JUMP_MODE:    jump_mode = value[0];
        REG_DECRYPT_MODE: decrypt_mode = value[0];
        default: ;
      endcase
    endfunction

    function bit [31:0] grid();
      return (precision == 0) ? 32'd1 : precision;
    endfunction

    function bit [31:0] seed_value();
      return (seed > grid()) ? grid() : seed;
    endfunction

    function bit [31:0] next_chaos(bit [31:0] k);
      bit [63:0]  p;
      bit [63:0]  kk;
      bit [63:0]  mu;
      bit [127:0] prod;
      p    = {32'd0, grid()};
      mu   = (mu_q > MU_CAP) ? {31'd0, MU_CAP} : {31'd0, mu_q};
      kk   = ({32'd0, k} > p) ? p : {32'd0, k};
      prod = {64'd0, mu} * {64'd0, kk} * {64'd0, p - kk};
      prod = (prod / {64'd0, p}) >> MF;
      if (prod > {64'd0, p}) prod = {64'd0, p};
      return prod[31:0];
    endfunction

    // data word that makes the ciphertext byte equal cipher
    function bit [7:0] data_for(bit [7:0] cipher, bit start);
      bit [31:0] k;
      k = start ? seed_value() : chaos;
      return decrypt_mode ? cipher : (cipher ^ k[7:0]);
    endfunction

    function void note_word(bit [7:0] data, bit start);
      bit [7:0] res;
      bit [7:0] cipher;
      if (start) chaos = seed_value();
      res        = data ^ chaos[7:0];
      cipher     = decrypt_mode ? data : res;
      last_steps = jump_mode ? cipher : 1;
      repeat (last_steps) chaos = next_chaos(chaos);
      expected_bytes.push_back(res);
      words_in++;
    endfunction

    task report(string msg);
      errors++;
      $display("error: %s", msg);
    endtask

    task check_result(bit [7:0] got);
      bit [7:0] want;
      words_out++;
      if (expected_bytes.size() == 0) begin
        report($sformatf("result_byte %02h with no word pending", got));
      end else begin
        want = expected_bytes.pop_front();
        if (got != want)
          report($sformatf("result_byte %02h, want %02h (result %0d)", got, want, words_out));
      end
    endtask
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic [7:0]           data_byte_i;
  logic                 start_of_message_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic [7:0]           result_byte_o;

  byte_cipher_checker chk;
  bit                 idle_on;
  bit                 hold_req;
  int unsigned        quiet_cycles;
  int unsigned        settings;
  int unsigned        jump_words;

  logistic_map_byte_cipher_top uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .data_byte_i        (data_byte_i),
    .start_of_message_i (start_of_message_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .result_byte_o      (result_byte_o)
  );

  always #5 clk_i = ~clk_i;

  // result check and watchdog
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) chk.check_result(result_byte_o);
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("logistic_map_byte_cipher_top regression: fail");
      $finish;
    end
  end

  // receiver: random stalls, one long hold-off on request
  initial begin
    int unsigned n;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_stall_i = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
      end
      n = idle_on ? $urandom_range(0, 8) : 0;
      if (n != 0) begin
        out_stall_i = 1'b1;
        repeat (n) @(negedge clk_i);
      end
      out_stall_i = 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  task write_reg(logic [CFG_IDX_W-1:0] idx, bit [CFG_W-1:0] value);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    chk.set_reg(idx, value);
  endtask

  task set_config(bit [32:0] mu, bit [32:0] prec, bit [32:0] sd, bit jm, bit dm);
    write_reg(REG_MU_Q, mu);
    write_reg(REG_PRECISION, prec);
    write_reg(REG_SEED, sd);
    // junk above bit 0 of the mode registers
    write_reg(REG_JUMP_MODE, {$urandom(), jm});
    write_reg(REG_DECRYPT_MODE, {$urandom(), dm});
    settings++;
  endtask

  task send_word(bit [7:0] data, bit start);
    int unsigned gap;
    in_valid_i         = 1'b1;
    data_byte_i        = data;
    start_of_message_i = start;
    do @(posedge clk_i); while (in_stall_o);
    chk.note_word(data, start);
    if (chk.jump_mode) jump_words++;
    @(negedge clk_i);
    in_valid_i = 1'b0;
    gap = idle_on ? $urandom_range(0, 8) : 0;
    repeat (gap) @(negedge clk_i);
  endtask

  // block keeps stepping the map after its result leaves
  task wait_idle();
    while (chk.expected_bytes.size() != 0) @(posedge clk_i);
    repeat (chk.last_steps * STEP_CYCLES + 20) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  initial begin
    bit [32:0]   mu;
    bit [32:0]   prec;
    bit [32:0]   sd;
    bit          jm;
    bit [7:0]    cipher;
    bit [7:0]    data;
    bit          start;
    int unsigned phase;
    int unsigned nwords;
    int unsigned r;

    chk                = new();
    clk_i              = 1'b0;
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_idx_i          = '0;
    cfg_data_i         = '0;
    in_valid_i         = 1'b0;
    data_byte_i        = 8'h00;
    start_of_message_i = 1'b0;
    idle_on            = 1'b1;
    hold_req           = 1'b0;
    quiet_cycles       = 0;
    settings           = 0;
    jump_words         = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset settings, data extremes
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(8'hA5, 1'b1);
    send_word(8'h5A, 1'b0);
    wait_idle();
    // zero precision, seed above grid, gain above 4.0
    set_config(33'h1_FFFF_FFFF, 33'd0, 33'd7, 1'b0, 1'b0);
    send_word(8'h3C, 1'b1);
    send_word(8'hFF, 1'b0);
    send_word(8'h00, 1'b0);
    wait_idle();
    set_config(MU_CAP, 33'hFFFF_FFFF, 33'hFFFF_FFFF, 1'b0, 1'b1);
    send_word(8'hC3, 1'b1);
    send_word(8'h81, 1'b0);
    send_word(8'h7E, 1'b0);
    wait_idle();
    set_config(33'h0_F000_0000, 33'd100000, 33'd12345, 1'b1, 1'b1);
    send_word(8'h00, 1'b1);
    send_word(8'h02, 1'b0);
    send_word(8'h00, 1'b0);
    send_word(8'h01, 1'b0);
    wait_idle();
    // grid lowered under the current state, jump encrypt
    set_config(33'h0_F000_0000, 33'd50, 33'd12345, 1'b1, 1'b0);
    send_word(chk.data_for(8'd0, 1'b0), 1'b0);
    send_word(chk.data_for(8'd3, 1'b0), 1'b0);
    send_word(chk.data_for(8'd255, 1'b0), 1'b0);
    send_word(chk.data_for(8'd1, 1'b1), 1'b1);
    wait_idle();
    set_config(33'd0, 33'd256, 33'd200, 1'b0, 1'b0);
    send_word(8'h5A, 1'b1);
    send_word(8'hA5, 1'b0);

    phase = 0;
    while (chk.words_in < TOTAL_WORDS) begin
      wait_idle();
      case ($urandom_range(0, 5))
        0:       mu = 33'd0;
        1:       mu = MU_CAP;
        2:       mu = 33'h1_FFFF_FFFF;
        3:       mu = MU_RESET;
        4:       mu = {1'($urandom_range(0, 1)), $urandom()};
        default: mu = 33'h0_E000_0000 + 33'($urandom_range(0, 32'h1FFF_FFFF));
      endcase
      case ($urandom_range(0, 7))
        0:       prec = 33'd0;
        1:       prec = 33'd1;
        2:       prec = 33'($urandom_range(2, 300));
        3:       prec = 33'd256;
        4:       prec = 33'd1000000;
        5:       prec = 33'hFFFF_FFFF;
        6:       prec = 33'($urandom());
        default: prec = 33'($urandom_range(1000, 5000000));
      endcase
      case ($urandom_range(0, 3))
        0:       sd = 33'd0;
        1:       sd = 33'hFFFF_FFFF;
        2:       sd = 33'($urandom());
        default: sd = 33'($urandom_range(0, prec[31:0]));
      endcase
      jm = (phase == 0) ? 1'b0 : ($urandom_range(0, 9) < 3);
      set_config(mu, prec, sd, jm, 1'($urandom_range(0, 1)));
      idle_on = (phase == 0) || ($urandom_range(0, 3) != 0);
      if (phase == 0) hold_req = 1'b1;
      nwords = (phase == 0) ? 40 : $urandom_range(10, 50);
      for (int i = 0; i < nwords; i++) begin
        start = (i == 0) ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 24) == 0);
        if (jm) begin
          r = $urandom_range(0, 99);
          if (r < 2) cipher = 8'd255;
          else if (r < 8) cipher = 8'($urandom_range(9, 40));
          else cipher = 8'($urandom_range(0, 8));
          data = chk.data_for(cipher, start);
        end else begin
          data = 8'($urandom_range(0, 255));
        end
        send_word(data, start);
      end
      phase++;
    end

    wait_idle();
    while (chk.expected_bytes.size() != 0)
      chk.report($sformatf("result_byte %02h never came", chk.expected_bytes.pop_front()));
    $display("%0d words in, %0d results checked, %0d register settings, %0d jump words",
             chk.words_in, chk.words_out, settings, jump_words);
    $display("%0d mismatches", chk.errors);
    if (chk.errors == 0) begin
      $display("logistic_map_byte_cipher_top regression: pass");
    end else begin
      $display("logistic_map_byte_cipher_top regression: fail");
    end
    $finish;
  end

endmodule
